### sv/ddq_pkg.sv
// Shared types and constants of the double-ended queue.
package ddq_pkg;

	localparam int ActionWidth   = 3;
	localparam int ValueWidth    = 32;
	localparam int PositionWidth = 5;
	localparam int ReadWidth     = 32;
	localparam int StatusWidth   = 2;
	localparam int CountWidth    = 6;

	localparam logic [ActionWidth-1:0] ACT_PUSH_BACK  = 3'd0;
	localparam logic [ActionWidth-1:0] ACT_PUSH_FRONT = 3'd1;
	localparam logic [ActionWidth-1:0] ACT_POP_BACK   = 3'd2;
	localparam logic [ActionWidth-1:0] ACT_POP_FRONT  = 3'd3;
	localparam logic [ActionWidth-1:0] ACT_READ       = 3'd4;

	localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
	localparam logic [StatusWidth-1:0] ST_FULL  = 2'd1;
	localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd2;
	localparam logic [StatusWidth-1:0] ST_RANGE = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                   enq_back;
		logic                   enq_front;
		logic                   deq_back;
		logic                   deq_front;
		logic                   rd_issue;
		logic                   load_out;
		logic                   load_rd;
		logic [StatusWidth-1:0] status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic pos_ok;
		logic out_free;
	} stat_t;

endpackage

### sv/ddq_req_if.sv
// Request channel: one action per transaction.
interface ddq_req_if;
	logic                                valid;
	logic                                ready;
	logic [ddq_pkg::ActionWidth-1:0]     action;
	logic [ddq_pkg::ValueWidth-1:0]      value;
	logic [ddq_pkg::PositionWidth-1:0]   position;

	modport source (output valid, action, value, position, input ready);
	modport sink   (input valid, action, value, position, output ready);
endinterface

### sv/ddq_rsp_if.sv
// Response channel: one result per transaction.
interface ddq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [ddq_pkg::ReadWidth-1:0]     read_value;
	logic [ddq_pkg::StatusWidth-1:0]   status;
	logic [ddq_pkg::CountWidth-1:0]    count;

	modport source (output valid, read_value, status, count, input ready);
	modport sink   (input valid, read_value, status, count, output ready);
endinterface

### sv/double_ended_queue.sv
// Double-ended queue of fixed capacity held as a ring in a single-port-write memory.
// Results: a push, a pop or a rejected action reaches the output register in the cycle
// after acceptance; a valid read passes the memory's registered read port first.
// Throughput: one action per cycle; a valid read holds off the next action until loaded.
// A result waiting in the output register does not block the next action if it is taken.
// Reset (arst_n low) empties the queue and clears the front pointer; store contents stay.
module double_ended_queue #(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	ddq_req_if.sink   req,
	ddq_rsp_if.source rsp
);

	ddq_pkg::cmd_t  cmd;
	ddq_pkg::stat_t stat;

	ddq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.action    (req.action),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ddq_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.value      (req.value),
		.position   (req.position),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.read_value (rsp.read_value),
		.status     (rsp.status),
		.count      (rsp.count)
	);

	// At most one queue operation is commanded per cycle.
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.enq_back, cmd.enq_front, cmd.deq_back, cmd.deq_front, cmd.rd_issue}))
		else $error("more than one queue operation in a cycle");

	// A read issued to the memory is delivered to the output register in the next cycle.
	a_rd_follow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |=> (cmd.load_rd && !req.ready))
		else $error("read data not loaded after issue");

	// The queue cannot be full and empty at once.
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("queue reports full and empty");

endmodule

### sv/ddq_ctrl.sv
// Controller of the double-ended queue: decodes actions into datapath commands.
module ddq_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic [ddq_pkg::ActionWidth-1:0] action,
	output logic                            req_ready,
	input  ddq_pkg::stat_t                  stat,
	output ddq_pkg::cmd_t                   cmd
);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;
	logic   accept;

	assign req_ready = (state_q == S_IDLE) && stat.out_free;
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd         = '0;
		cmd.status  = ddq_pkg::ST_OK;
		cmd.load_rd = (state_q == S_READ);
		if (accept) begin
			cmd.load_out = 1'b1;
			case (action)
				ddq_pkg::ACT_PUSH_BACK: begin
					if (stat.full) cmd.status = ddq_pkg::ST_FULL;
					else cmd.enq_back = 1'b1;
				end
				ddq_pkg::ACT_PUSH_FRONT: begin
					if (stat.full) cmd.status = ddq_pkg::ST_FULL;
					else cmd.enq_front = 1'b1;
				end
				ddq_pkg::ACT_POP_BACK: begin
					if (stat.empty) cmd.status = ddq_pkg::ST_EMPTY;
					else cmd.deq_back = 1'b1;
				end
				ddq_pkg::ACT_POP_FRONT: begin
					if (stat.empty) cmd.status = ddq_pkg::ST_EMPTY;
					else cmd.deq_front = 1'b1;
				end
				ddq_pkg::ACT_READ: begin
					// A valid read waits for the memory's registered data before loading the output register.
					if (stat.pos_ok) begin
						cmd.rd_issue = 1'b1;
						cmd.load_out = 1'b0;
					end else begin
						cmd.status = ddq_pkg::ST_RANGE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.rd_issue) state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/ddq_dp.sv
// Datapath of the double-ended queue: ring store, pointer, count and result register.
module ddq_dp #(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ddq_pkg::cmd_t                     cmd,
	output ddq_pkg::stat_t                    stat,
	input  logic [ddq_pkg::ValueWidth-1:0]    value,
	input  logic [ddq_pkg::PositionWidth-1:0] position,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [ddq_pkg::ReadWidth-1:0]     read_value,
	output logic [ddq_pkg::StatusWidth-1:0]   status,
	output logic [ddq_pkg::CountWidth-1:0]    count
);

	localparam int PW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int SW   = CW + 1;
	localparam int CMPW = (CW > ddq_pkg::PositionWidth) ? CW : ddq_pkg::PositionWidth;

	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_data_q;

	logic [PW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic          out_valid_q;
	logic [ddq_pkg::ReadWidth-1:0]   rv_q;
	logic [ddq_pkg::StatusWidth-1:0] st_q;
	logic [ddq_pkg::CountWidth-1:0]  cnt_q;

	logic [SW-1:0] back_sum, rd_sum;
	logic [PW-1:0] back_slot, rd_slot, front_dec, front_inc, wr_addr;
	logic [CW-1:0] count_nxt;
	logic [63:0]   value_ext, rd_ext;
	logic [DATA_WIDTH-1:0] wr_data;

	assign stat.full     = (count_q == CW'(CAPACITY));
	assign stat.empty    = (count_q == '0);
	assign stat.pos_ok   = (CMPW'(position) < CMPW'(count_q));
	assign stat.out_free = !out_valid_q || rsp_ready;

	// Ring slots: the sum stays below twice the capacity, so one subtract wraps it.
	assign back_sum  = SW'(front_q) + SW'(count_q);
	assign back_slot = (back_sum >= SW'(CAPACITY)) ? PW'(back_sum - SW'(CAPACITY))
	                                               : PW'(back_sum);
	assign rd_sum    = SW'(front_q) + SW'(CW'(position));
	assign rd_slot   = (rd_sum >= SW'(CAPACITY)) ? PW'(rd_sum - SW'(CAPACITY))
	                                             : PW'(rd_sum);
	assign front_dec = (front_q == '0) ? PW'(CAPACITY - 1) : front_q - 1'b1;
	assign front_inc = (front_q == PW'(CAPACITY - 1)) ? '0 : front_q + 1'b1;

	always_comb begin
		count_nxt = count_q;
		if (cmd.enq_back || cmd.enq_front) count_nxt = count_q + 1'b1;
		else if (cmd.deq_back || cmd.deq_front) count_nxt = count_q - 1'b1;
	end

	assign value_ext = 64'(value);
	assign wr_data   = value_ext[DATA_WIDTH-1:0];
	assign wr_addr   = cmd.enq_front ? front_dec : back_slot;
	assign rd_ext    = 64'(rd_data_q);

	always_ff @(posedge clk) begin
		if (cmd.enq_back || cmd.enq_front) mem[wr_addr] <= wr_data;
		if (cmd.rd_issue) rd_data_q <= mem[rd_slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (cmd.enq_front) front_q <= front_dec;
			else if (cmd.deq_front) front_q <= front_inc;
			if (cmd.load_out || cmd.load_rd) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rv_q  <= '0;
			st_q  <= cmd.status;
			cnt_q <= ddq_pkg::CountWidth'(count_nxt);
		end else if (cmd.load_rd) begin
			rv_q  <= rd_ext[ddq_pkg::ReadWidth-1:0];
			st_q  <= ddq_pkg::ST_OK;
			cnt_q <= ddq_pkg::CountWidth'(count_q);
		end
	end

	assign rsp_valid  = out_valid_q;
	assign read_value = rv_q;
	assign status     = st_q;
	assign count      = cnt_q;

endmodule
